// File: src/grcd_pkg.sv
// ----------------------------------------------------------------------------
// grcd_pkg
// Shared constants, codes and types of the glyph run command decoder.
// ----------------------------------------------------------------------------
package grcd_pkg;

  // Row buffer size and derived widths.
  localparam int ROW_BITS   = 32;
  localparam int COL_W      = $clog2(ROW_BITS);
  localparam int CNT_W      = COL_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIM_W      = 6;
  localparam int COORD_W    = 16;
  localparam int CLIP_W     = 12;
  localparam int COLOR_W    = 8;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_GLYPH_WIDTH  = 32;
  localparam int DEF_MAX_GLYPH_HEIGHT = 32;
  localparam int DEF_CLIP_LEFT        = 0;
  localparam int DEF_CLIP_TOP         = 0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_LENGTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INK_COLOR    = 3'd7;

  // Two-bit command codes, first bit in the MSB.
  localparam logic [1:0] CMD_REPEAT    = 2'b00;
  localparam logic [1:0] CMD_COPY_ROW  = 2'b10;
  localparam logic [1:0] CMD_COPY_WORD = 2'b01;
  localparam logic [1:0] CMD_ZERO_WORD = 2'b11;

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0]   RST_GLYPH_WIDTH  = 6'd8;
  localparam logic [DIM_W-1:0]   RST_GLYPH_HEIGHT = 6'd8;
  localparam logic [DIM_W-1:0]   RST_WORD_LENGTH  = 6'd8;
  localparam logic [CLIP_W-1:0]  RST_CLIP_RIGHT   = 12'd480;
  localparam logic [CLIP_W-1:0]  RST_CLIP_BOTTOM  = 12'd272;

  typedef enum logic [5:0] {
    PH_CMD0 = 6'b000001,
    PH_CMD1 = 6'b000010,
    PH_SUB  = 6'b000100,
    PH_RAW  = 6'b001000,
    PH_COPY = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } seq_state_t;

  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_BIT  = 2'd1,
    SRC_PREV = 2'd2
  } pix_src_t;

  typedef struct packed {
    logic             clear;
    logic             fire;
    pix_src_t         src;
    logic             bit_val;
    logic [CNT_W-1:0] idx;
  } pix_ctrl_t;

  typedef struct packed {
    logic             at_origin;
    logic             row_full;
    logic             done_now;
    logic [COL_W-1:0] col;
  } pix_stat_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               on;
    logic               draw;
    logic               done;
  } pix_out_t;

endpackage

// File: src/grcd_rem_div.sv
// ----------------------------------------------------------------------------
// grcd_rem_div
// Bit-serial restoring divider that finds the start of the word holding a
// column: base = column - (column mod word_length), one bit per cycle.
// ----------------------------------------------------------------------------
module grcd_rem_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [grcd_pkg::COL_W-1:0]  col,
  input  logic [grcd_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [grcd_pkg::CNT_W-1:0]  base
);

  localparam int STEP_W = $clog2(grcd_pkg::COL_W + 1);

  logic                        active_r, active_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [grcd_pkg::COL_W-1:0]  shift_r, shift_nxt;
  logic [grcd_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [grcd_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [grcd_pkg::CNT_W-1:0]  rem_sh;
  logic [grcd_pkg::CNT_W-1:0]  rem_step;

  // The partial remainder stays below the divisor, so its top bit is free.
  assign rem_sh   = {rem_r[grcd_pkg::CNT_W-2:0], shift_r[grcd_pkg::COL_W-1]};
  assign rem_step = (rem_sh >= divisor) ? rem_sh - divisor : rem_sh;

  assign done = active_r && (step_r == STEP_W'(1));
  assign base = {1'b0, col_r} - rem_step;

  always_comb begin
    active_nxt = active_r;
    step_nxt   = step_r;
    shift_nxt  = shift_r;
    col_nxt    = col_r;
    rem_nxt    = rem_r;
    if (start) begin
      active_nxt = 1'b1;
      step_nxt   = STEP_W'(grcd_pkg::COL_W);
      shift_nxt  = col;
      col_nxt    = col;
      rem_nxt    = '0;
    end else if (active_r) begin
      rem_nxt   = rem_step;
      shift_nxt = {shift_r[grcd_pkg::COL_W-2:0], 1'b0};
      step_nxt  = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      step_r   <= '0;
    end else begin
      active_r <= active_nxt;
      step_r   <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    col_r   <= col_nxt;
    rem_r   <= rem_nxt;
  end

endmodule

// File: src/grcd_pixel_unit.sv
// ----------------------------------------------------------------------------
// grcd_pixel_unit
// Row buffers and pixel position counters. Builds one pixel per fire with
// its screen coordinates and clip result, and wraps rows at the width.
// ----------------------------------------------------------------------------
module grcd_pixel_unit #(
  parameter int CLIP_LEFT = grcd_pkg::DEF_CLIP_LEFT,
  parameter int CLIP_TOP  = grcd_pkg::DEF_CLIP_TOP
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  grcd_pkg::pix_ctrl_t           ctrl,
  input  logic [grcd_pkg::CNT_W-1:0]    eff_width,
  input  logic [grcd_pkg::DIM_W-1:0]    eff_height,
  input  logic [grcd_pkg::COORD_W-1:0]  origin_x,
  input  logic [grcd_pkg::COORD_W-1:0]  origin_y,
  input  logic [grcd_pkg::CLIP_W-1:0]   clip_right,
  input  logic [grcd_pkg::CLIP_W-1:0]   clip_bottom,
  output grcd_pkg::pix_stat_t           stat,
  output grcd_pkg::pix_out_t            pix
);

  localparam int CMP_W = grcd_pkg::COORD_W + 1;
  localparam logic signed [CMP_W-1:0] CLIP_LEFT_S = CMP_W'(CLIP_LEFT);
  localparam logic signed [CMP_W-1:0] CLIP_TOP_S  = CMP_W'(CLIP_TOP);

  logic [grcd_pkg::COL_W-1:0]     col_r;
  logic [grcd_pkg::DIM_W-1:0]     row_r;
  logic [grcd_pkg::ROW_BITS-1:0]  cur_row_r;
  logic [grcd_pkg::ROW_BITS-1:0]  prev_row_r;

  logic                           prev_bit;
  logic                           on;
  logic [grcd_pkg::ROW_BITS-1:0]  row_upd;
  logic [grcd_pkg::CNT_W-1:0]     col_inc;
  logic [grcd_pkg::DIM_W-1:0]     row_inc;
  logic                           wrap;
  logic [grcd_pkg::COORD_W-1:0]   sx, sy;
  logic signed [CMP_W-1:0]        sx_s, sy_s, right_s, bottom_s;
  logic                           in_x, in_y;

  always_comb begin
    // Reads at or past the row width give zero.
    prev_bit = (ctrl.idx < eff_width) ? prev_row_r[ctrl.idx[grcd_pkg::COL_W-1:0]] : 1'b0;
    case (ctrl.src)
      grcd_pkg::SRC_PREV: on = prev_bit;
      grcd_pkg::SRC_BIT:  on = ctrl.bit_val;
      default:            on = 1'b0;
    endcase
    row_upd        = cur_row_r;
    row_upd[col_r] = on;
    col_inc = grcd_pkg::CNT_W'(col_r) + grcd_pkg::CNT_W'(1);
    row_inc = row_r + grcd_pkg::DIM_W'(1);
    wrap    = (col_inc >= eff_width);

    sx       = origin_x + grcd_pkg::COORD_W'(col_r);
    sy       = origin_y + grcd_pkg::COORD_W'(row_r);
    sx_s     = {sx[grcd_pkg::COORD_W-1], sx};
    sy_s     = {sy[grcd_pkg::COORD_W-1], sy};
    right_s  = CMP_W'(clip_right);
    bottom_s = CMP_W'(clip_bottom);
    in_x     = (sx_s >= CLIP_LEFT_S) && (sx_s < right_s);
    in_y     = (sy_s >= CLIP_TOP_S) && (sy_s < bottom_s);

    stat.at_origin = (row_r == '0) && (col_r == '0);
    stat.row_full  = (row_r >= eff_height);
    stat.done_now  = wrap && (row_inc >= eff_height);
    stat.col       = col_r;

    pix.x    = sx;
    pix.y    = sy;
    pix.on   = on;
    pix.draw = on && in_x && in_y;
    pix.done = stat.done_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      col_r      <= '0;
      row_r      <= '0;
      cur_row_r  <= '0;
      prev_row_r <= '0;
    end else if (ctrl.fire) begin
      cur_row_r <= row_upd;
      if (wrap) begin
        prev_row_r <= row_upd;
        col_r      <= '0;
        row_r      <= row_inc;
      end else begin
        col_r <= col_inc[grcd_pkg::COL_W-1:0];
      end
    end
  end

endmodule

// File: src/glyph_run_command_decoder.sv
// ----------------------------------------------------------------------------
// glyph_run_command_decoder
// Decodes a serial compressed glyph stream into clipped screen pixels.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Word
//  in_      sink       in_valid/in_ready     one stream bit and a glyph start flag
//  out_     source     out_valid/out_ready   one pixel with coordinates and flags
//  cfg_     sink       cfg_wr_en             register index and write data
//
// A raw or copy bit is decoded in the idle state, then its pixel is emitted.
// Repeat and zero-word commands emit up to 32 pixels, one per cycle while the
// output is not stalled, and a repeat-word first runs the bit-serial divider.
// Command bits that make no pixel are taken without leaving the idle state.
// Reset is synchronous and acts like a glyph start with default registers.
// With out_ready low the pixel waits in the output register and emission pauses.
// ----------------------------------------------------------------------------
module glyph_run_command_decoder #(
  parameter int MAX_GLYPH_WIDTH  = grcd_pkg::DEF_MAX_GLYPH_WIDTH,
  parameter int MAX_GLYPH_HEIGHT = grcd_pkg::DEF_MAX_GLYPH_HEIGHT,
  parameter int CLIP_LEFT        = grcd_pkg::DEF_CLIP_LEFT,
  parameter int CLIP_TOP         = grcd_pkg::DEF_CLIP_TOP
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_stream_bit,
  input  logic                             in_glyph_start,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [grcd_pkg::COORD_W-1:0] out_pixel_x,
  output logic signed [grcd_pkg::COORD_W-1:0] out_pixel_y,
  output logic                             out_pixel_on,
  output logic                             out_draw_enable,
  output logic [grcd_pkg::COLOR_W-1:0]     out_pixel_color,
  output logic                             out_run_last,
  output logic                             out_glyph_done,
  input  logic                             cfg_wr_en,
  input  logic [grcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [grcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int W_LIMIT = (MAX_GLYPH_WIDTH < grcd_pkg::ROW_BITS) ?
                           MAX_GLYPH_WIDTH : grcd_pkg::ROW_BITS;
  localparam int H_CMP_W = grcd_pkg::DIM_W + 1;

  // Configuration registers.
  logic [grcd_pkg::DIM_W-1:0]    glyph_width_r, glyph_height_r, word_length_r;
  logic [grcd_pkg::COORD_W-1:0]  origin_x_r, origin_y_r;
  logic [grcd_pkg::CLIP_W-1:0]   clip_right_r, clip_bottom_r;
  logic [grcd_pkg::COLOR_W-1:0]  ink_color_r;

  logic [grcd_pkg::CNT_W-1:0]    eff_width, eff_word;
  logic [grcd_pkg::DIM_W-1:0]    eff_height;

  // Sequencer.
  grcd_pkg::seq_state_t          state_r, state_nxt;
  grcd_pkg::phase_t              phase_r, phase_nxt, phase_eff;
  logic                          cmd_first_r, cmd_first_nxt, cmd_first_eff;
  logic [grcd_pkg::CNT_W-1:0]    copy_rem_r, copy_rem_nxt, copy_rem_eff, copy_dec;
  grcd_pkg::pix_src_t            src_r, src_nxt;
  logic                          bit_r, bit_nxt;
  logic [grcd_pkg::CNT_W-1:0]    idx_r, idx_nxt;
  logic [grcd_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [1:0]                    cmd;
  logic                          accept;
  logic                          slot_free;
  logic                          at_origin_eff;

  logic                          div_start, div_done;
  logic [grcd_pkg::CNT_W-1:0]    div_base;

  grcd_pkg::pix_ctrl_t           ctrl;
  grcd_pkg::pix_stat_t           stat;
  grcd_pkg::pix_out_t            pix;

  // Output register.
  logic                          out_valid_r;
  logic [grcd_pkg::COORD_W-1:0]  out_x_r, out_y_r;
  logic                          out_on_r, out_draw_r, out_last_r, out_done_r;
  logic [grcd_pkg::COLOR_W-1:0]  out_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r  <= grcd_pkg::RST_GLYPH_WIDTH;
      glyph_height_r <= grcd_pkg::RST_GLYPH_HEIGHT;
      word_length_r  <= grcd_pkg::RST_WORD_LENGTH;
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      clip_right_r   <= grcd_pkg::RST_CLIP_RIGHT;
      clip_bottom_r  <= grcd_pkg::RST_CLIP_BOTTOM;
      ink_color_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        grcd_pkg::REG_GLYPH_WIDTH:  glyph_width_r  <= cfg_data[grcd_pkg::DIM_W-1:0];
        grcd_pkg::REG_GLYPH_HEIGHT: glyph_height_r <= cfg_data[grcd_pkg::DIM_W-1:0];
        grcd_pkg::REG_WORD_LENGTH:  word_length_r  <= cfg_data[grcd_pkg::DIM_W-1:0];
        grcd_pkg::REG_ORIGIN_X:     origin_x_r     <= cfg_data[grcd_pkg::COORD_W-1:0];
        grcd_pkg::REG_ORIGIN_Y:     origin_y_r     <= cfg_data[grcd_pkg::COORD_W-1:0];
        grcd_pkg::REG_CLIP_RIGHT:   clip_right_r   <= cfg_data[grcd_pkg::CLIP_W-1:0];
        grcd_pkg::REG_CLIP_BOTTOM:  clip_bottom_r  <= cfg_data[grcd_pkg::CLIP_W-1:0];
        grcd_pkg::REG_INK_COLOR:    ink_color_r    <= cfg_data[grcd_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero registers count as one; width, height and word length saturate at their limits.
  always_comb begin
    if (glyph_width_r == '0) begin
      eff_width = grcd_pkg::CNT_W'(1);
    end else if (grcd_pkg::CNT_W'(glyph_width_r) > grcd_pkg::CNT_W'(W_LIMIT)) begin
      eff_width = grcd_pkg::CNT_W'(W_LIMIT);
    end else begin
      eff_width = grcd_pkg::CNT_W'(glyph_width_r);
    end

    if (glyph_height_r == '0) begin
      eff_height = grcd_pkg::DIM_W'(1);
    end else if (H_CMP_W'(glyph_height_r) > H_CMP_W'(MAX_GLYPH_HEIGHT)) begin
      eff_height = grcd_pkg::DIM_W'(MAX_GLYPH_HEIGHT);
    end else begin
      eff_height = glyph_height_r;
    end

    if (word_length_r == '0) begin
      eff_word = grcd_pkg::CNT_W'(1);
    end else if (grcd_pkg::CNT_W'(word_length_r) > grcd_pkg::CNT_W'(grcd_pkg::ROW_BITS)) begin
      eff_word = grcd_pkg::CNT_W'(grcd_pkg::ROW_BITS);
    end else begin
      eff_word = grcd_pkg::CNT_W'(word_length_r);
    end
  end

  assign in_ready  = (state_r == grcd_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    // A glyph start clears the decoder before this bit is decoded.
    phase_eff     = in_glyph_start ? grcd_pkg::PH_CMD0 : phase_r;
    cmd_first_eff = in_glyph_start ? 1'b0 : cmd_first_r;
    copy_rem_eff  = in_glyph_start ? '0 : copy_rem_r;
    at_origin_eff = in_glyph_start || stat.at_origin;
    cmd           = {cmd_first_eff, in_stream_bit};
    copy_dec      = (copy_rem_eff != '0) ? copy_rem_eff - grcd_pkg::CNT_W'(1) : '0;

    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cmd_first_nxt = cmd_first_r;
    copy_rem_nxt  = copy_rem_r;
    src_nxt       = src_r;
    bit_nxt       = bit_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    div_start     = 1'b0;

    ctrl.clear   = 1'b0;
    ctrl.fire    = 1'b0;
    ctrl.src     = src_r;
    ctrl.bit_val = bit_r;
    ctrl.idx     = idx_r;

    case (state_r)
      grcd_pkg::S_IDLE: begin
        if (accept) begin
          ctrl.clear    = in_glyph_start;
          phase_nxt     = phase_eff;
          cmd_first_nxt = cmd_first_eff;
          copy_rem_nxt  = copy_rem_eff;
          bit_nxt       = in_stream_bit;
          case (phase_eff)
            grcd_pkg::PH_CMD0: begin
              cmd_first_nxt = in_stream_bit;
              phase_nxt     = grcd_pkg::PH_CMD1;
            end
            grcd_pkg::PH_CMD1: begin
              cmd_first_nxt = in_stream_bit;
              case (cmd)
                grcd_pkg::CMD_REPEAT: begin
                  // Only the first command of a glyph can switch to raw bits.
                  phase_nxt = at_origin_eff ? grcd_pkg::PH_RAW : grcd_pkg::PH_SUB;
                end
                grcd_pkg::CMD_COPY_ROW: begin
                  copy_rem_nxt = eff_width;
                  phase_nxt    = grcd_pkg::PH_COPY;
                end
                grcd_pkg::CMD_COPY_WORD: begin
                  copy_rem_nxt = eff_word;
                  phase_nxt    = grcd_pkg::PH_COPY;
                end
                default: begin
                  phase_nxt = grcd_pkg::PH_CMD0;
                  src_nxt   = grcd_pkg::SRC_ZERO;
                  count_nxt = eff_word;
                  state_nxt = grcd_pkg::S_EMIT;
                end
              endcase
            end
            grcd_pkg::PH_SUB: begin
              phase_nxt = grcd_pkg::PH_CMD0;
              if (in_stream_bit) begin
                src_nxt   = grcd_pkg::SRC_PREV;
                idx_nxt   = '0;
                count_nxt = eff_width;
                state_nxt = grcd_pkg::S_EMIT;
              end else begin
                div_start = 1'b1;
                state_nxt = grcd_pkg::S_DIV;
              end
            end
            grcd_pkg::PH_RAW: begin
              src_nxt   = grcd_pkg::SRC_BIT;
              count_nxt = grcd_pkg::CNT_W'(1);
              state_nxt = grcd_pkg::S_EMIT;
            end
            grcd_pkg::PH_COPY: begin
              copy_rem_nxt = copy_dec;
              phase_nxt    = (copy_dec == '0) ? grcd_pkg::PH_CMD0 : grcd_pkg::PH_COPY;
              src_nxt      = grcd_pkg::SRC_BIT;
              count_nxt    = grcd_pkg::CNT_W'(1);
              state_nxt    = grcd_pkg::S_EMIT;
            end
            default: begin
              phase_nxt = grcd_pkg::PH_DONE;
            end
          endcase
        end
      end
      grcd_pkg::S_DIV: begin
        if (div_done) begin
          src_nxt   = grcd_pkg::SRC_PREV;
          idx_nxt   = div_base;
          count_nxt = eff_word;
          state_nxt = grcd_pkg::S_EMIT;
        end
      end
      grcd_pkg::S_EMIT: begin
        if (slot_free) begin
          if (phase_r == grcd_pkg::PH_DONE) begin
            state_nxt = grcd_pkg::S_IDLE;
          end else if (stat.row_full) begin
            // The height shrank below the rows already written.
            phase_nxt = grcd_pkg::PH_DONE;
            state_nxt = grcd_pkg::S_IDLE;
          end else begin
            ctrl.fire = 1'b1;
            count_nxt = count_r - grcd_pkg::CNT_W'(1);
            idx_nxt   = idx_r + grcd_pkg::CNT_W'(1);
            if (stat.done_now) begin
              phase_nxt = grcd_pkg::PH_DONE;
            end
            if (stat.done_now || (count_r == grcd_pkg::CNT_W'(1))) begin
              state_nxt = grcd_pkg::S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = grcd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grcd_pkg::S_IDLE;
      phase_r     <= grcd_pkg::PH_CMD0;
      cmd_first_r <= 1'b0;
      copy_rem_r  <= '0;
      src_r       <= grcd_pkg::SRC_ZERO;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cmd_first_r <= cmd_first_nxt;
      copy_rem_r  <= copy_rem_nxt;
      src_r       <= src_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
    idx_r <= idx_nxt;
  end

  grcd_rem_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .col     (stat.col),
    .divisor (eff_word),
    .done    (div_done),
    .base    (div_base)
  );

  grcd_pixel_unit #(
    .CLIP_LEFT (CLIP_LEFT),
    .CLIP_TOP  (CLIP_TOP)
  ) u_pixel (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .eff_width   (eff_width),
    .eff_height  (eff_height),
    .origin_x    (origin_x_r),
    .origin_y    (origin_y_r),
    .clip_right  (clip_right_r),
    .clip_bottom (clip_bottom_r),
    .stat        (stat),
    .pix         (pix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      out_x_r     <= pix.x;
      out_y_r     <= pix.y;
      out_on_r    <= pix.on;
      out_draw_r  <= pix.draw;
      out_color_r <= ink_color_r;
      out_last_r  <= stat.done_now || (count_r == grcd_pkg::CNT_W'(1));
      out_done_r  <= pix.done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_on    = out_on_r;
  assign out_draw_enable = out_draw_r;
  assign out_pixel_color = out_color_r;
  assign out_run_last    = out_last_r;
  assign out_glyph_done  = out_done_r;

endmodule

// File: src/grcd_checker.sv
// ----------------------------------------------------------------------------
// grcd_checker
// Port-level checks of the glyph run command decoder, bound to the top level.
// ----------------------------------------------------------------------------
module grcd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_stream_bit,
  input logic                             in_glyph_start,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [grcd_pkg::COORD_W-1:0]     out_pixel_x,
  input logic [grcd_pkg::COORD_W-1:0]     out_pixel_y,
  input logic                             out_pixel_on,
  input logic                             out_draw_enable,
  input logic [grcd_pkg::COLOR_W-1:0]     out_pixel_color,
  input logic                             out_run_last,
  input logic                             out_glyph_done
);

  // A waiting input word must hold until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_stream_bit) &&
      $stable(in_glyph_start))
    else $error("input word changed while waiting");

  // A stalled word must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_x) &&
      $stable(out_pixel_y) && $stable(out_pixel_on) && $stable(out_draw_enable) &&
      $stable(out_pixel_color) && $stable(out_run_last) && $stable(out_glyph_done))
    else $error("output word changed while stalled");

  // Only ink pixels are ever drawn.
  a_draw_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_draw_enable |-> out_pixel_on)
    else $error("draw enable set on a blank pixel");

  // The final pixel of a glyph always closes its run.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_glyph_done |-> out_run_last)
    else $error("glyph done without run last");

  // No word can appear in the cycle right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind glyph_run_command_decoder grcd_checker u_grcd_checker (.*);

// File: bench/glyph_run_command_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_run_command_decoder_tb
// Feeds compressed glyph bit streams through the decoder under random source
// and sink stalls. A behavioral decoder in the bench predicts every pixel, and
// each pixel coming out is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module glyph_run_command_decoder_tb;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RAND_WORDS    = 50;
  localparam int COL_LIMIT     = (grcd_pkg::DEF_MAX_GLYPH_WIDTH < grcd_pkg::ROW_BITS) ?
                                 grcd_pkg::DEF_MAX_GLYPH_WIDTH : grcd_pkg::ROW_BITS;

  typedef struct packed {
    logic sbit;
    logic start;
  } stream_bit_t;

  typedef struct packed {
    logic [grcd_pkg::COORD_W-1:0] x;
    logic [grcd_pkg::COORD_W-1:0] y;
    logic                         on;
    logic                         draw;
    logic [grcd_pkg::COLOR_W-1:0] color;
    logic                         last;
    logic                         done;
  } pixel_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              in_stream_bit = 1'b0;
  logic                              in_glyph_start = 1'b0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [grcd_pkg::COORD_W-1:0] out_pixel_x;
  logic signed [grcd_pkg::COORD_W-1:0] out_pixel_y;
  logic                              out_pixel_on;
  logic                              out_draw_enable;
  logic [grcd_pkg::COLOR_W-1:0]      out_pixel_color;
  logic                              out_run_last;
  logic                              out_glyph_done;
  logic                              cfg_wr_en = 1'b0;
  logic [grcd_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [grcd_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  glyph_run_command_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_stream_bit   (in_stream_bit),
    .in_glyph_start  (in_glyph_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_on    (out_pixel_on),
    .out_draw_enable (out_draw_enable),
    .out_pixel_color (out_pixel_color),
    .out_run_last    (out_run_last),
    .out_glyph_done  (out_glyph_done),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the register file.
  logic [grcd_pkg::DIM_W-1:0]   r_width, r_height, r_word;
  logic [grcd_pkg::COORD_W-1:0] r_org_x, r_org_y;
  logic [grcd_pkg::CLIP_W-1:0]  r_clip_r, r_clip_b;
  logic [grcd_pkg::COLOR_W-1:0] r_ink;

  // Bench copy of the decoder state.
  grcd_pkg::phase_t ph;
  logic [1:0]       cmd_bits;
  int               copy_left, col_cnt, row_cnt;
  logic [31:0]      cur_row, prev_row;
  int               step_n;

  stream_bit_t pend_q[$];
  pixel_t      pixel_q[$];
  int          item_cnt = 0;
  int          errors = 0;
  int          cycles = 0;
  logic        bit_taken = 1'b0;
  logic        pix_taken = 1'b0;
  int          tx_gap = 0;
  int          rx_wait = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;

  function automatic int clamp_dim(logic [grcd_pkg::DIM_W-1:0] v, int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic int glyph_cols();
    return clamp_dim(r_width, COL_LIMIT);
  endfunction

  function automatic int glyph_rows();
    return clamp_dim(r_height, grcd_pkg::DEF_MAX_GLYPH_HEIGHT);
  endfunction

  function automatic int word_cols();
    return clamp_dim(r_word, grcd_pkg::ROW_BITS);
  endfunction

  function automatic void restart_glyph();
    ph = grcd_pkg::PH_CMD0;
    cmd_bits = 2'b00;
    copy_left = 0;
    col_cnt = 0;
    row_cnt = 0;
    cur_row = '0;
    prev_row = '0;
  endfunction

  function automatic logic prev_pixel(int i);
    if (i >= glyph_cols()) return 1'b0;
    return prev_row[i];
  endfunction

  // Places one pixel at the current column and advances the raster position.
  function automatic void put_pixel(logic on);
    int          w, h, col, xi, yi;
    logic [15:0] sx, sy;
    logic        drw, fin;
    pixel_t      p;
    w = glyph_cols();
    h = glyph_rows();
    col = col_cnt & 31;
    fin = 1'b0;
    if (ph == grcd_pkg::PH_DONE) return;
    if (row_cnt >= h) begin
      ph = grcd_pkg::PH_DONE;
      return;
    end
    sx = r_org_x + 16'(col);
    sy = r_org_y + 16'(row_cnt);
    xi = int'($signed(sx));
    yi = int'($signed(sy));
    cur_row[col] = on;
    drw = on && xi >= grcd_pkg::DEF_CLIP_LEFT && xi < int'(r_clip_r) &&
          yi >= grcd_pkg::DEF_CLIP_TOP && yi < int'(r_clip_b);
    if (col + 1 >= w) begin
      prev_row = cur_row;
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) begin
        fin = 1'b1;
        ph = grcd_pkg::PH_DONE;
      end
    end else begin
      col_cnt = col + 1;
    end
    p = '{x: sx, y: sy, on: on, draw: drw, color: r_ink, last: 1'b0, done: fin};
    pixel_q.push_back(p);
    step_n++;
  endfunction

  // Decodes one accepted stream bit and queues the pixels it produces.
  function automatic void decode_bit(logic b, logic s);
    int         n_px, base;
    logic [1:0] cmd;
    pixel_t     p;
    step_n = 0;
    if (s) restart_glyph();
    case (ph)
      grcd_pkg::PH_CMD0: begin
        cmd_bits = {1'b0, b};
        ph = grcd_pkg::PH_CMD1;
      end
      grcd_pkg::PH_CMD1: begin
        cmd = {cmd_bits[0], b};
        cmd_bits = cmd;
        case (cmd)
          grcd_pkg::CMD_REPEAT: begin
            // Only the very first command of a glyph switches to raw bits.
            if (row_cnt == 0 && col_cnt == 0) ph = grcd_pkg::PH_RAW;
            else ph = grcd_pkg::PH_SUB;
          end
          grcd_pkg::CMD_COPY_ROW: begin
            copy_left = glyph_cols();
            ph = grcd_pkg::PH_COPY;
          end
          grcd_pkg::CMD_COPY_WORD: begin
            copy_left = word_cols();
            ph = grcd_pkg::PH_COPY;
          end
          default: begin
            ph = grcd_pkg::PH_CMD0;
            n_px = word_cols();
            repeat (n_px) put_pixel(1'b0);
          end
        endcase
      end
      grcd_pkg::PH_SUB: begin
        ph = grcd_pkg::PH_CMD0;
        if (b) begin
          n_px = glyph_cols();
          for (int i = 0; i < n_px; i++) put_pixel(prev_pixel(i));
        end else begin
          n_px = word_cols();
          base = ((col_cnt & 31) / n_px) * n_px;
          for (int i = base; i < base + n_px; i++) put_pixel(prev_pixel(i));
        end
      end
      grcd_pkg::PH_RAW: put_pixel(b);
      grcd_pkg::PH_COPY: begin
        if (copy_left > 0) copy_left--;
        if (copy_left == 0) ph = grcd_pkg::PH_CMD0;
        put_pixel(b);
      end
      default: ph = grcd_pkg::PH_DONE;
    endcase
    if (step_n > 0) begin
      p = pixel_q.pop_back();
      p.last = 1'b1;
      pixel_q.push_back(p);
    end
  endfunction

  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 9) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic report_pixel(string what, pixel_t want, pixel_t got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s: got x=%0d y=%0d on=%b draw=%b color=%0d last=%b done=%b,",
               $realtime, what, $signed(got.x), $signed(got.y), got.on, got.draw,
               got.color, got.last, got.done,
               " expected x=%0d y=%0d on=%b draw=%b color=%0d last=%b done=%b",
               $signed(want.x), $signed(want.y), want.on, want.draw, want.color,
               want.last, want.done);
  endtask

  // Stream driver: after each word it idles for a drawn number of cycles before the next.
  always @(negedge clk) begin : driver
    stream_bit_t item;
    if (rst_n) begin
      if (in_valid && !bit_taken) begin
        // Word still waiting for acceptance; hold it.
      end else if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (pend_q.size() > 0) begin
        item = pend_q.pop_front();
        in_valid <= 1'b1;
        in_stream_bit <= item.sbit;
        in_glyph_start <= item.start;
        tx_gap <= draw_wait(tx_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Pixel sink: after each accepted pixel, stall for a drawn number of cycles.
  always @(negedge clk) begin : receiver
    int s;
    if (rst_n) begin
      s = pix_taken ? draw_wait(rx_burst) : rx_wait;
      if (s > 0) begin
        out_ready <= 1'b0;
        rx_wait <= s - 1;
      end else begin
        out_ready <= 1'b1;
        rx_wait <= 0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    pixel_t got, want;
    if (!rst_n) begin
      bit_taken <= 1'b0;
      pix_taken <= 1'b0;
    end else begin
      bit_taken <= in_valid && in_ready;
      pix_taken <= out_valid && out_ready;
      if (in_valid && in_ready) decode_bit(in_stream_bit, in_glyph_start);
      if (out_valid && out_ready) begin
        got = '{x: out_pixel_x, y: out_pixel_y, on: out_pixel_on,
                draw: out_draw_enable, color: out_pixel_color,
                last: out_run_last, done: out_glyph_done};
        if (pixel_q.size() == 0) begin
          report_pixel("unexpected pixel", '0, got);
        end else begin
          want = pixel_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.on !== want.on ||
              got.draw !== want.draw || got.color !== want.color ||
              got.last !== want.last || got.done !== want.done)
            report_pixel("pixel mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("glyph_run_command_decoder_tb: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic [grcd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    logic [15:0] mask;
    logic [15:0] data;
    case (idx)
      grcd_pkg::REG_GLYPH_WIDTH, grcd_pkg::REG_GLYPH_HEIGHT,
      grcd_pkg::REG_WORD_LENGTH: mask = 16'h003F;
      grcd_pkg::REG_CLIP_RIGHT, grcd_pkg::REG_CLIP_BOTTOM: mask = 16'h0FFF;
      grcd_pkg::REG_INK_COLOR: mask = 16'h00FF;
      default: mask = 16'hFFFF;
    endcase
    // Bits above the register width are junk and must be ignored.
    data = (16'($urandom()) & ~mask) | (val & mask);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      grcd_pkg::REG_GLYPH_WIDTH:  r_width = data[grcd_pkg::DIM_W-1:0];
      grcd_pkg::REG_GLYPH_HEIGHT: r_height = data[grcd_pkg::DIM_W-1:0];
      grcd_pkg::REG_WORD_LENGTH:  r_word = data[grcd_pkg::DIM_W-1:0];
      grcd_pkg::REG_ORIGIN_X:     r_org_x = data;
      grcd_pkg::REG_ORIGIN_Y:     r_org_y = data;
      grcd_pkg::REG_CLIP_RIGHT:   r_clip_r = data[grcd_pkg::CLIP_W-1:0];
      grcd_pkg::REG_CLIP_BOTTOM:  r_clip_b = data[grcd_pkg::CLIP_W-1:0];
      default:                    r_ink = data[grcd_pkg::COLOR_W-1:0];
    endcase
  endtask

  task automatic load_config(int w, int h, int wl, logic [15:0] ox, logic [15:0] oy,
                             int cr, int cb, int ink);
    write_reg(grcd_pkg::REG_GLYPH_WIDTH, 16'(w));
    write_reg(grcd_pkg::REG_GLYPH_HEIGHT, 16'(h));
    write_reg(grcd_pkg::REG_WORD_LENGTH, 16'(wl));
    write_reg(grcd_pkg::REG_ORIGIN_X, ox);
    write_reg(grcd_pkg::REG_ORIGIN_Y, oy);
    write_reg(grcd_pkg::REG_CLIP_RIGHT, 16'(cr));
    write_reg(grcd_pkg::REG_CLIP_BOTTOM, 16'(cb));
    write_reg(grcd_pkg::REG_INK_COLOR, 16'(ink));
  endtask

  // Waits until the stream is drained and every predicted pixel has come out.
  task automatic drain();
    while (pend_q.size() != 0 || in_valid || pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_bit(logic b, logic s);
    pend_q.push_back('{sbit: b, start: s});
    item_cnt++;
  endtask

  task automatic put_cmd(logic [1:0] c, logic s);
    put_bit(c[1], s);
    put_bit(c[0], 1'b0);
  endtask

  // Well-formed command glyph with random content. With cut set, the sender
  // stops halfway, waits for all pixels, and changes the width and origin x mid-glyph.
  task automatic cmd_glyph(bit rows_only, bit cut);
    int w, h, wl, pix, target, pick;
    bit first, was_cut;
    w = glyph_cols();
    h = glyph_rows();
    wl = word_cols();
    pix = 0;
    target = w * h;
    first = 1'b1;
    was_cut = 1'b0;
    while (pix < target) begin
      if (cut && !was_cut && pix > 0 && pix >= target / 2) begin
        drain();
        write_reg(grcd_pkg::REG_GLYPH_WIDTH, 16'($urandom_range(1, 6)));
        write_reg(grcd_pkg::REG_ORIGIN_X, 16'($urandom_range(0, 400)));
        w = glyph_cols();
        target = (h - row_cnt) * w;
        pix = 0;
        was_cut = 1'b1;
      end else begin
        if (rows_only) pick = (first || $urandom_range(0, 15) == 0) ? 0 : 3;
        else pick = $urandom_range(0, first ? 2 : 4);
        case (pick)
          0: begin
            put_cmd(grcd_pkg::CMD_COPY_ROW, first);
            repeat (w) put_bit($urandom_range(0, 1), 1'b0);
            pix += w;
          end
          1: begin
            put_cmd(grcd_pkg::CMD_COPY_WORD, first);
            repeat (wl) put_bit($urandom_range(0, 1), 1'b0);
            pix += wl;
          end
          2: begin
            put_cmd(grcd_pkg::CMD_ZERO_WORD, first);
            pix += wl;
          end
          3: begin
            put_cmd(grcd_pkg::CMD_REPEAT, 1'b0);
            put_bit(1'b1, 1'b0);
            pix += w;
          end
          default: begin
            put_cmd(grcd_pkg::CMD_REPEAT, 1'b0);
            put_bit(1'b0, 1'b0);
            pix += wl;
          end
        endcase
        first = 1'b0;
      end
    end
    repeat ($urandom_range(0, 2)) put_bit($urandom_range(0, 1), 1'b0);
  endtask

  task automatic raw_glyph();
    put_cmd(grcd_pkg::CMD_REPEAT, 1'b1);
    repeat (glyph_cols() * glyph_rows() + $urandom_range(0, 2))
      put_bit($urandom_range(0, 1), 1'b0);
  endtask

  task automatic noise_glyph();
    put_bit($urandom_range(0, 1), 1'b1);
    repeat ($urandom_range(4, 24))
      put_bit($urandom_range(0, 1), $urandom_range(0, 11) == 0);
  endtask

  initial begin : stimulus
    int base_cnt, phase_no, w, h, wl, kind;
    logic [15:0] ox, oy;
    int cr, cb, ink;
    r_width = grcd_pkg::RST_GLYPH_WIDTH;
    r_height = grcd_pkg::RST_GLYPH_HEIGHT;
    r_word = grcd_pkg::RST_WORD_LENGTH;
    r_org_x = '0;
    r_org_y = '0;
    r_clip_r = grcd_pkg::RST_CLIP_RIGHT;
    r_clip_b = grcd_pkg::RST_CLIP_BOTTOM;
    r_ink = '0;
    restart_glyph();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // 5x4 glyph, word of 4, top row above the window and a 3-column clip.
    load_config(5, 4, 4, 16'h0000, 16'hFFFF, 3, 4095, 255);
    put_cmd(grcd_pkg::CMD_COPY_ROW, 1'b1);
    put_bit(1'b1, 1'b0); put_bit(1'b1, 1'b0); put_bit(1'b0, 1'b0);
    put_bit(1'b1, 1'b0); put_bit(1'b1, 1'b0);
    put_cmd(grcd_pkg::CMD_ZERO_WORD, 1'b0);
    // Repeat-word at the last column: the word runs past the row end and wraps.
    put_cmd(grcd_pkg::CMD_REPEAT, 1'b0); put_bit(1'b0, 1'b0);
    put_cmd(grcd_pkg::CMD_COPY_WORD, 1'b0);
    put_bit(1'b1, 1'b0); put_bit(1'b0, 1'b0); put_bit(1'b1, 1'b0); put_bit(1'b1, 1'b0);
    // Repeat-row that overruns the glyph end, then a bit after the glyph is done.
    put_cmd(grcd_pkg::CMD_REPEAT, 1'b0); put_bit(1'b1, 1'b0);
    put_bit(1'b1, 1'b0);
    // Raw glyph cut short by a new glyph that starts with a zero word.
    put_cmd(grcd_pkg::CMD_REPEAT, 1'b1);
    put_bit(1'b1, 1'b0); put_bit(1'b0, 1'b0);
    put_cmd(grcd_pkg::CMD_ZERO_WORD, 1'b1);
    drain();

    // Zero sizes act as one, oversized words saturate to the row buffer.
    load_config(0, 0, 63, 16'h7FFF, 16'h8000, 4095, 4095, 0);
    put_cmd(grcd_pkg::CMD_ZERO_WORD, 1'b1);
    raw_glyph();
    drain();

    // Widest glyph, saturated to the row buffer, built mostly from row repeats.
    load_config(63, 2, 0, 16'd4080, 16'd4080, 4095, 4095, 255);
    cmd_glyph(1'b1, 1'b0);
    drain();

    base_cnt = item_cnt;
    phase_no = 0;
    while (item_cnt - base_cnt < RAND_WORDS) begin
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = 63;
        2: w = 32;
        default: w = $urandom_range(1, 6);
      endcase
      if (w >= 32) h = $urandom_range(1, 3);
      else begin
        case ($urandom_range(0, 9))
          0: h = 0;
          1: h = 40;
          default: h = $urandom_range(1, 4);
        endcase
      end
      case ($urandom_range(0, 9))
        0: wl = 0;
        1: wl = 63;
        default: wl = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 5))
        0: ox = 16'h8000;
        1: ox = 16'h7FFF;
        2: ox = 16'hFFFE;
        default: ox = 16'($urandom_range(0, 600));
      endcase
      case ($urandom_range(0, 5))
        0: oy = 16'h8000;
        1: oy = 16'h7FFE;
        2: oy = 16'hFFFF;
        default: oy = 16'($urandom_range(0, 300));
      endcase
      case ($urandom_range(0, 5))
        0: cr = 0;
        1: cr = 4095;
        default: cr = $urandom_range(0, 600);
      endcase
      case ($urandom_range(0, 5))
        0: cb = 0;
        1: cb = 4095;
        default: cb = $urandom_range(0, 300);
      endcase
      case ($urandom_range(0, 4))
        0: ink = 0;
        1: ink = 255;
        default: ink = $urandom_range(0, 255);
      endcase
      load_config(w, h, wl, ox, oy, cr, cb, ink);
      repeat ($urandom_range(1, 2)) begin
        kind = $urandom_range(0, 9);
        if (kind < 6) cmd_glyph(1'b0, phase_no == 0 || $urandom_range(0, 4) == 0);
        else if (kind < 8) begin
          if (glyph_cols() * glyph_rows() <= 40) raw_glyph();
          else cmd_glyph(1'b0, 1'b0);
        end else noise_glyph();
      end
      drain();
      phase_no++;
    end

    drain();
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("glyph_run_command_decoder_tb: done, clean");
    end else begin
      $display("glyph_run_command_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: glyph_run_command_decoder.f
src/grcd_pkg.sv
src/grcd_rem_div.sv
src/grcd_pixel_unit.sv
src/glyph_run_command_decoder.sv
src/grcd_checker.sv
bench/glyph_run_command_decoder_tb.sv
